// ===== rtl/core/tps_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tps_pkg;

  // Note table size: the smaller of the note count and the table length.
  localparam int NOTES      = 24;
  localparam int TABLE_LEN  = 24;
  localparam int ROM_SIZE   = (NOTES < TABLE_LEN) ? NOTES : TABLE_LEN;

  localparam logic [9:0] US_PER_MS = 10'd1000;

  // Request codes carried in the input tuser field.
  localparam logic [2:0] REQ_TICK  = 3'd0;
  localparam logic [2:0] REQ_PLAY  = 3'd1;
  localparam logic [2:0] REQ_ALARM = 3'd2;
  localparam logic [2:0] REQ_SONAR = 3'd3;
  localparam logic [2:0] REQ_STOP  = 3'd4;

  // Configuration register indexes.
  localparam logic [2:0] CFG_ALARM_MS     = 3'd0;
  localparam logic [2:0] CFG_PING_MS      = 3'd1;
  localparam logic [2:0] CFG_GAP_MS       = 3'd2;
  localparam logic [2:0] CFG_ALARM_FIRST  = 3'd3;
  localparam logic [2:0] CFG_ALARM_SECOND = 3'd4;
  localparam logic [2:0] CFG_PING_NOTE    = 3'd5;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_SINGLE = 2'd1,
    MODE_ALARM  = 2'd2,
    MODE_SONAR  = 2'd3
  } tps_mode_t;

  typedef struct packed {
    logic [11:0] period;
    logic [11:0] pulse;
  } tps_tone_t;

  typedef struct packed {
    logic [15:0] siren_ms;
    logic [15:0] ping_ms;
    logic [15:0] gap_ms;
    logic [4:0]  alarm_first_note;
    logic [4:0]  alarm_second_note;
    logic [4:0]  ping_note;
  } tps_cfg_t;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [4:0]  note;
    logic [15:0] length_ms;
  } tps_item_t;

  // Declared from the top bit down so pwm_period lands in the lowest bits.
  typedef struct packed {
    logic        step_advanced;
    logic [1:0]  play_mode;
    logic        running;
    logic [11:0] pwm_compare;
    logic [11:0] pwm_period;
  } tps_result_t;

  localparam tps_tone_t TONE_TABLE [TABLE_LEN] = '{
    '{12'd3815, 12'd1907}, '{12'd3609, 12'd1804}, '{12'd3400, 12'd1700},
    '{12'd3214, 12'd1607}, '{12'd3029, 12'd1514}, '{12'd2864, 12'd1432},
    '{12'd2701, 12'd1350}, '{12'd2550, 12'd1275}, '{12'd2408, 12'd1204},
    '{12'd2271, 12'd1135}, '{12'd2144, 12'd1072}, '{12'd2023, 12'd1011},
    '{12'd1911, 12'd955},  '{12'd1804, 12'd902},  '{12'd1702, 12'd851},
    '{12'd1606, 12'd803},  '{12'd1516, 12'd758},  '{12'd1431, 12'd715},
    '{12'd1350, 12'd675},  '{12'd1274, 12'd637},  '{12'd1202, 12'd601},
    '{12'd1135, 12'd567},  '{12'd1071, 12'd535},  '{12'd1011, 12'd505}
  };

  // Indexes at or beyond the table size fall back to the last entry.
  function automatic tps_tone_t tone_lookup(input logic [4:0] note);
    logic [4:0] idx;
    idx = (note < 5'(ROM_SIZE)) ? note : 5'(ROM_SIZE - 1);
    return TONE_TABLE[idx];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/tps_cfg_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tps_cfg_regs (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_index,
  input  logic [15:0]      cfg_wdata,
  output tps_pkg::tps_cfg_t cfg
);
  import tps_pkg::*;

  // Writes to indexes past the last register are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.siren_ms          <= 16'd300;
      cfg.ping_ms           <= 16'd150;
      cfg.gap_ms            <= 16'd850;
      cfg.alarm_first_note  <= 5'd9;
      cfg.alarm_second_note <= 5'd16;
      cfg.ping_note         <= 5'd12;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ALARM_MS:     cfg.siren_ms          <= cfg_wdata;
        CFG_PING_MS:      cfg.ping_ms           <= cfg_wdata;
        CFG_GAP_MS:       cfg.gap_ms            <= cfg_wdata;
        CFG_ALARM_FIRST:  cfg.alarm_first_note  <= cfg_wdata[4:0];
        CFG_ALARM_SECOND: cfg.alarm_second_note <= cfg_wdata[4:0];
        CFG_PING_NOTE:    cfg.ping_note         <= cfg_wdata[4:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/tps_in_reg.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tps_in_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [2:0]        s_tuser,
  input  logic [23:0]       s_tdata,
  input  logic              stage_ready,
  output logic              item_valid,
  output tps_pkg::tps_item_t item
);
  import tps_pkg::*;

  // The register frees up whenever the engine takes its item this cycle.
  assign s_tready = !item_valid || stage_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_tready) begin
      item_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      item.req_type  <= s_tuser;
      item.note      <= s_tdata[4:0];
      item.length_ms <= s_tdata[20:5];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/tps_engine.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tps_engine (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  input  tps_pkg::tps_item_t  item,
  input  tps_pkg::tps_cfg_t   cfg,
  input  logic                out_ready,
  output logic                stage_ready,
  output logic                out_valid,
  output tps_pkg::tps_result_t result
);
  import tps_pkg::*;

  logic [26:0] elapsed_time, elapsed_time_next;
  logic [25:0] target_time, target_time_next;
  tps_mode_t   mode_reg, mode_reg_next;
  logic        siren_step, siren_step_next;
  logic        in_gap, in_gap_next;
  logic        timer_on, timer_on_next;
  logic [11:0] period_ticks, period_ticks_next;
  logic [11:0] compare_ticks, compare_ticks_next;

  logic        fire;
  logic        advanced;
  logic        arm;
  logic        arm_tone;
  logic [4:0]  sel_note;
  logic [15:0] sel_ms;
  logic [26:0] tick_sum;
  tps_tone_t   tone;

  assign stage_ready = !out_valid || out_ready;
  assign fire        = item_valid && stage_ready;

  assign tone     = tone_lookup(sel_note);
  assign tick_sum = elapsed_time + {15'd0, period_ticks} + 27'd1;

  always_comb begin
    elapsed_time_next  = elapsed_time;
    target_time_next   = target_time;
    mode_reg_next      = mode_reg;
    siren_step_next    = siren_step;
    in_gap_next        = in_gap;
    timer_on_next      = timer_on;
    period_ticks_next  = period_ticks;
    compare_ticks_next = compare_ticks;
    advanced           = 1'b0;
    arm                = 1'b0;
    arm_tone           = 1'b1;
    sel_note           = cfg.ping_note;
    sel_ms             = cfg.ping_ms;

    unique case (item.req_type)
      REQ_TICK: begin
        if (timer_on) begin
          elapsed_time_next = tick_sum;
          if (tick_sum >= {1'b0, target_time}) begin
            advanced = 1'b1;
            unique case (mode_reg)
              MODE_ALARM: begin
                siren_step_next = ~siren_step;
                arm             = 1'b1;
                sel_note        = siren_step ? cfg.alarm_first_note
                                             : cfg.alarm_second_note;
                sel_ms          = cfg.siren_ms;
              end
              MODE_SONAR: begin
                arm         = 1'b1;
                in_gap_next = ~in_gap;
                if (!in_gap) begin
                  arm_tone = 1'b0;
                  sel_ms   = cfg.gap_ms;
                end
              end
              MODE_IDLE, MODE_SINGLE: begin
                timer_on_next = 1'b0;
                mode_reg_next = MODE_IDLE;
              end
            endcase
          end
        end
      end
      REQ_PLAY: begin
        mode_reg_next = MODE_SINGLE;
        arm           = 1'b1;
        sel_note      = item.note;
        sel_ms        = item.length_ms;
      end
      REQ_ALARM: begin
        mode_reg_next   = MODE_ALARM;
        siren_step_next = 1'b0;
        arm             = 1'b1;
        sel_note        = cfg.alarm_first_note;
        sel_ms          = cfg.siren_ms;
      end
      REQ_SONAR: begin
        mode_reg_next = MODE_SONAR;
        in_gap_next   = 1'b0;
        arm           = 1'b1;
      end
      REQ_STOP: begin
        mode_reg_next = MODE_IDLE;
        timer_on_next = 1'b0;
      end
      default: ;
    endcase

    // Arming restarts the step timer; a silent gap keeps the period.
    if (arm) begin
      elapsed_time_next = 27'd0;
      target_time_next  = 26'({10'd0, sel_ms} * {16'd0, US_PER_MS});
      if (arm_tone) begin
        period_ticks_next  = tone.period;
        compare_ticks_next = tone.pulse;
        timer_on_next      = 1'b1;
      end else begin
        compare_ticks_next = 12'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      elapsed_time  <= 27'd0;
      target_time   <= 26'd0;
      mode_reg      <= MODE_IDLE;
      siren_step    <= 1'b0;
      in_gap        <= 1'b0;
      timer_on      <= 1'b0;
      period_ticks  <= 12'd0;
      compare_ticks <= 12'd0;
    end else if (fire) begin
      elapsed_time  <= elapsed_time_next;
      target_time   <= target_time_next;
      mode_reg      <= mode_reg_next;
      siren_step    <= siren_step_next;
      in_gap        <= in_gap_next;
      timer_on      <= timer_on_next;
      period_ticks  <= period_ticks_next;
      compare_ticks <= compare_ticks_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (stage_ready) begin
      out_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      result.pwm_period    <= period_ticks_next;
      result.pwm_compare   <= compare_ticks_next;
      result.running       <= timer_on_next;
      result.play_mode     <= mode_reg_next;
      result.step_advanced <= advanced;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/tone_pattern_sequencer_core.sv =====
// A request is captured in the input register and then in the result register, where
// m_tvalid rises; backpressure can hold it in between. Throughput: one item per cycle
// unless the result side stalls; each item is a single compare-and-update of the step state.
// Backpressure on the result side stalls the input register after at most one more transfer.
// Reset (rst, synchronous, active high): play state cleared to idle with zero period
// and compare; configuration registers return to their default durations and notes.
`timescale 1ns / 1ps
`default_nettype none

module tone_pattern_sequencer_core (
  input  logic        clk,
  input  logic        rst,
  // Request stream.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [2:0]  s_tuser,   // [2:0] req_type
  input  logic [23:0] s_tdata,   // [4:0] note, [20:5] note length in ms, [23:21] zero
  // Result stream.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [11:0] pwm_period, [23:12] pwm_compare,
                                 // [24] running, [26:25] play_mode,
                                 // [27] step_advanced, [31:28] zero
  // Configuration write port.
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);
  import tps_pkg::*;

  tps_cfg_t    cfg;
  tps_item_t   item;
  tps_result_t result;
  logic        item_valid;
  logic        stage_ready;

  // Configuration registers. New durations and notes are picked up the next
  // time a note or gap is armed; the current step runs out unchanged.
  tps_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Input register. It accepts a new transfer whenever its current item
  // moves on to the engine in the same cycle, so the stream runs at full rate unless the result side stalls.
  tps_in_reg u_in (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tuser     (s_tuser),
    .s_tdata     (s_tdata),
    .stage_ready (stage_ready),
    .item_valid  (item_valid),
    .item        (item)
  );

  // Sequencer engine: the play state, the note table lookup, the step timer
  // and the result register. A tick while the timer is stopped, and any
  // unknown request code, leave the state alone and report it unchanged.
  tps_engine u_engine (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item        (item),
    .cfg         (cfg),
    .out_ready   (m_tready),
    .stage_ready (stage_ready),
    .out_valid   (m_tvalid),
    .result      (result)
  );

  assign m_tdata = {4'd0, result};

endmodule

`default_nettype wire

// ===== rtl/core/tps_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tps_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata
);
  import tps_pkg::*;

  // A stalled result holds still.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // The input side only stalls behind a waiting result.
  a_stall: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid && !m_tready)
    else $error("input stalled without output backpressure");

  // The timer runs exactly when a mode other than idle is active.
  a_run_mode: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[24] == (m_tdata[26:25] != MODE_IDLE)))
    else $error("running flag disagrees with play mode");

  // A running timer with zero compare is only a sonar gap.
  a_gap: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[24] && (m_tdata[23:12] == 12'd0) |-> m_tdata[26:25] == MODE_SONAR)
    else $error("silent output outside sonar mode");

endmodule

bind tone_pattern_sequencer_core tps_checker u_tps_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire
